// ===== design/kwsm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kwsm_pkg;

  // Sequence count and per-sequence FIFO depth (depth must be a power of two).
  localparam int unsigned NUM_LISTS  = 8;
  localparam int unsigned LIST_DEPTH = 256;

  // Word field widths.
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned SEL_W   = 3;

  // Derived widths.
  localparam int unsigned LIST_W  = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int unsigned PTR_W   = $clog2(LIST_DEPTH);
  localparam int unsigned FILL_W  = PTR_W + 1;
  localparam int unsigned SCAN_W  = $clog2(NUM_LISTS + 1);
  localparam int unsigned ADDR_W  = LIST_W + PTR_W;
  localparam int unsigned STORE_DEPTH = NUM_LISTS * LIST_DEPTH;

  // Command codes.
  localparam logic CMD_APPEND = 1'b0;
  localparam logic CMD_POP    = 1'b1;

endpackage

`default_nettype wire

// ===== design/kwsm_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface kwsm_in_if
  import kwsm_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic [SEL_W-1:0]           list_select;
  logic signed [VALUE_W-1:0]  value;

  modport source (output valid, output command, output list_select, output value,
                  input ready);
  modport sink   (input valid, input command, input list_select, input value,
                  output ready);
endinterface

`default_nettype wire

// ===== design/kwsm_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface kwsm_out_if
  import kwsm_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  min_value;
  logic [SEL_W-1:0]           source_list;
  logic                       all_empty;
  logic                       overflow_seen;

  modport source (output valid, output min_value, output source_list,
                  output all_empty, output overflow_seen, input ready);
  modport sink   (input valid, input min_value, input source_list,
                  input all_empty, input overflow_seen, output ready);
endinterface

`default_nettype wire

// ===== design/kwsm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kwsm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/k_way_sorted_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Append word: ready again the next cycle, no result word.
// Pop word: the heads are scanned through the one read port of the element RAM,
//   one head a cycle, then the result waits in S_DONE until the output register
//   is free; ready returns only once the result is registered, so pops never overlap.
// Reset (rst_ni low, asynchronous) empties every sequence and clears overflow;
//   the element RAM is not cleared and needs no clearing pass.

module k_way_sorted_merge
  import kwsm_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  kwsm_in_if.sink     in_i,
  kwsm_out_if.source  out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e state_q;

  // Per-sequence FIFO bookkeeping; read at one shared index per cycle.
  logic [PTR_W-1:0]  head_q [NUM_LISTS];
  logic [FILL_W-1:0] fill_q [NUM_LISTS];
  logic              overflow_q;

  // Scan sequencer.
  logic [SCAN_W-1:0]        rd_cnt_q;
  logic [LIST_W-1:0]        cmp_idx_q;
  logic                     cmp_vld_q;
  logic                     cmp_ne_q;
  logic                     found_q;
  logic [LIST_W-1:0]        best_idx_q;
  logic signed [VALUE_W-1:0] best_val_q;

  // Output register.
  logic                      out_valid_q;
  logic signed [VALUE_W-1:0] out_value_q;
  logic [SEL_W-1:0]          out_src_q;
  logic                      out_empty_q;
  logic                      out_ovf_q;

  logic                      in_acc;
  logic                      sel_ok;
  logic [LIST_W-1:0]         sel_idx;
  logic [LIST_W-1:0]         ptr_idx;
  logic [PTR_W-1:0]          head_rd;
  logic [FILL_W-1:0]         fill_rd;
  logic                      full;
  logic                      ram_we;
  logic                      ram_re;
  logic [ADDR_W-1:0]         ram_waddr;
  logic [ADDR_W-1:0]         ram_raddr;
  logic [VALUE_W-1:0]        ram_rdata;
  logic                      scan_issue;
  logic                      take_cand;
  logic                      out_free;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  // Ignore appends aimed past the last sequence.
  assign sel_ok  = (32'(in_i.list_select) < NUM_LISTS);
  assign sel_idx = LIST_W'(in_i.list_select);

  // One index into the bookkeeping per cycle: append target while idle, the
  // head being fetched during the scan, the winner while retiring.
  always_comb begin
    case (state_q)
      S_IDLE:  ptr_idx = sel_idx;
      S_SCAN:  ptr_idx = rd_cnt_q[LIST_W-1:0];
      S_DONE:  ptr_idx = best_idx_q;
      default: ptr_idx = best_idx_q;
    endcase
  end

  assign head_rd = head_q[ptr_idx];
  assign fill_rd = fill_q[ptr_idx];
  assign full    = (fill_rd == FILL_W'(LIST_DEPTH));

  // Tail slot wraps modulo the power-of-two depth by truncation.
  assign ram_we    = in_acc && (in_i.command == CMD_APPEND) && sel_ok && !full;
  assign ram_waddr = {ptr_idx, PTR_W'(head_rd + fill_rd[PTR_W-1:0])};

  assign scan_issue = (state_q == S_SCAN) && (32'(rd_cnt_q) < NUM_LISTS);
  assign ram_re     = scan_issue;
  assign ram_raddr  = {ptr_idx, head_rd};

  kwsm_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared comparator: strict less-than keeps the lowest index on a tie,
  // since heads arrive in index order.
  assign take_cand = cmp_vld_q && cmp_ne_q &&
                     (!found_q || ($signed(ram_rdata) < best_val_q));

  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      for (int i = 0; i < NUM_LISTS; i++) begin
        head_q[i] <= '0;
        fill_q[i] <= '0;
      end
      overflow_q  <= 1'b0;
      rd_cnt_q    <= '0;
      cmp_idx_q   <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_ne_q    <= 1'b0;
      found_q     <= 1'b0;
      best_idx_q  <= '0;
      best_val_q  <= '0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_src_q   <= '0;
      out_empty_q <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      // Drop the result word once taken, unless a new one replaces it.
      if (out_valid_q && out_o.ready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (in_i.command == CMD_POP) begin
              rd_cnt_q  <= '0;
              cmp_vld_q <= 1'b0;
              found_q   <= 1'b0;
              state_q   <= S_SCAN;
            end else if (sel_ok) begin
              if (full) begin
                overflow_q <= 1'b1;
              end else begin
                fill_q[ptr_idx] <= fill_rd + FILL_W'(1);
              end
            end
          end
        end

        S_SCAN: begin
          // Issue the next head fetch while comparing the previous one.
          cmp_vld_q <= scan_issue;
          if (scan_issue) begin
            cmp_idx_q <= ptr_idx;
            cmp_ne_q  <= (fill_rd != '0);
            rd_cnt_q  <= rd_cnt_q + SCAN_W'(1);
          end
          if (take_cand) begin
            found_q    <= 1'b1;
            best_idx_q <= cmp_idx_q;
            best_val_q <= $signed(ram_rdata);
          end
          if (!scan_issue && cmp_vld_q) begin
            state_q <= S_DONE;
          end
        end

        S_DONE: begin
          // Hold until the output register is free, then retire the winner.
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_ovf_q   <= overflow_q;
            if (found_q) begin
              head_q[ptr_idx] <= head_rd + PTR_W'(1);
              fill_q[ptr_idx] <= fill_rd - FILL_W'(1);
              out_value_q     <= best_val_q;
              out_src_q       <= SEL_W'(best_idx_q);
              out_empty_q     <= 1'b0;
            end else begin
              out_value_q <= '0;
              out_src_q   <= '0;
              out_empty_q <= 1'b1;
            end
            state_q <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.min_value     = out_value_q;
  assign out_o.source_list   = out_src_q;
  assign out_o.all_empty     = out_empty_q;
  assign out_o.overflow_seen = out_ovf_q;

endmodule

`default_nettype wire

// ===== design/kwsm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kwsm_checker
  import kwsm_pkg::*;
(
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_i,
  input wire logic                      in_command_i,
  input wire logic                      out_valid_i,
  input wire logic                      out_ready_i,
  input wire logic signed [VALUE_W-1:0] out_min_value_i,
  input wire logic [SEL_W-1:0]          out_source_list_i,
  input wire logic                      out_all_empty_i,
  input wire logic                      out_overflow_seen_i
);

  // Empty result carries zero value and source.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_all_empty_i |-> (out_min_value_i == '0) && (out_source_list_i == '0))
    else $error("empty result with nonzero fields");

  // A pop blocks further input while it scans.
  a_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_command_i == CMD_POP) |=> !in_ready_i)
    else $error("ready right after pop");

  // An append never makes a result word.
  a_append_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_command_i == CMD_APPEND) && !out_valid_i |=> !out_valid_i)
    else $error("result word after append");

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_min_value_i) &&
      $stable(out_source_list_i) && $stable(out_all_empty_i) && $stable(out_overflow_seen_i))
    else $error("stalled result word changed");

endmodule

bind k_way_sorted_merge kwsm_checker u_kwsm_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_i.valid),
  .in_ready_i          (in_i.ready),
  .in_command_i        (in_i.command),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .out_min_value_i     (out_o.min_value),
  .out_source_list_i   (out_o.source_list),
  .out_all_empty_i     (out_o.all_empty),
  .out_overflow_seen_i (out_o.overflow_seen)
);

`default_nettype wire

// ===== tb/sv/k_way_sorted_merge_tb.sv =====
`timescale 1ns / 1ps

module k_way_sorted_merge_tb;
  import kwsm_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned HOLD_AT      = 300;   // words accepted before the long hold-off
  localparam int unsigned HOLD_CYCLES  = 500;
  localparam int unsigned TAIL_CYCLES  = 4 * (NUM_LISTS + 3);
  localparam int unsigned NUM_ROWS     = 26;

  // One popped word as the block reports it.
  typedef struct packed {
    logic signed [VALUE_W-1:0] min_value;
    logic [SEL_W-1:0]          source_list;
    logic                      all_empty;
    logic                      overflow_seen;
  } merge_result_t;

  // One row of the directed table; pinned rows carry their result typed in.
  typedef struct packed {
    logic                      cmd;
    logic [SEL_W-1:0]          sel;
    logic signed [VALUE_W-1:0] val;
    logic                      pinned;
    merge_result_t             res;
  } word_row_t;

  logic clk_i;
  logic rst_ni;

  kwsm_in_if  in_if ();
  kwsm_out_if out_if ();

  k_way_sorted_merge dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow of the sequences: one queue per sequence, head at index 0.
  logic signed [VALUE_W-1:0] seq_q [NUM_LISTS][$];
  logic                      overflow_flag;
  // Last value appended per sequence, used to build ascending runs.
  logic signed [VALUE_W-1:0] last_val [NUM_LISTS];

  merge_result_t min_results_q [$];
  word_row_t     directed_rows [NUM_ROWS];

  int unsigned words_accepted;
  int unsigned burst_left;
  int unsigned fail_count;
  int unsigned cycle_count;
  bit          hold_done;

  // Apply one accepted word to the shadow; return the popped word for a pop.
  function automatic merge_result_t merge_step(logic cmd, logic [SEL_W-1:0] sel,
                                               logic signed [VALUE_W-1:0] val);
    merge_result_t r;
    int best;
    r = '0;
    best = -1;
    if (cmd == CMD_APPEND) begin
      if (sel < NUM_LISTS) begin
        // Drop the value on a full sequence and latch the overflow.
        if (seq_q[sel].size() >= LIST_DEPTH) overflow_flag = 1'b1;
        else seq_q[sel].push_back(val);
      end
    end else begin
      // Scan heads in index order; strict less-than keeps the lowest index on ties.
      for (int i = 0; i < NUM_LISTS; i++) begin
        if (seq_q[i].size() != 0 && (best < 0 || seq_q[i][0] < seq_q[best][0])) best = i;
      end
      if (best < 0) begin
        r.all_empty = 1'b1;
      end else begin
        r.min_value   = seq_q[best].pop_front();
        r.source_list = SEL_W'(best);
      end
      r.overflow_seen = overflow_flag;
    end
    return r;
  endfunction

  // Mostly ascending values per sequence, with copies across sequences for ties
  // and some unordered noise.
  function automatic logic signed [VALUE_W-1:0] next_value(logic [SEL_W-1:0] sel);
    longint nv;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return VALUE_W'($urandom);
    if (pick < 25) return last_val[$urandom_range(0, NUM_LISTS - 1)];
    nv = longint'(last_val[sel]) + longint'($urandom_range(0, (pick < 60) ? 3 : 5000));
    if (nv > 64'sd2147483647) begin
      // Restart the run near the bottom of the range or just above zero.
      if ($urandom_range(0, 1) != 0) return VALUE_W'(32'h8000_0000 + $urandom_range(0, 3));
      return VALUE_W'($urandom_range(0, 1000));
    end
    return nv[VALUE_W-1:0];
  endfunction

  task automatic report_mismatch(string what, merge_result_t want, merge_result_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $write("%0t %s: expected value=%0d list=%0d empty=%0b ovf=%0b, ",
             $realtime, what, want.min_value, want.source_list, want.all_empty,
             want.overflow_seen);
      $display("got value=%0d list=%0d empty=%0b ovf=%0b",
               got.min_value, got.source_list, got.all_empty, got.overflow_seen);
    end
  endtask

  // Offer one word, hold it until taken, then update the shadow and pace the sender.
  task automatic send_word(logic cmd, logic [SEL_W-1:0] sel, logic signed [VALUE_W-1:0] val,
                           logic pinned, merge_result_t pinned_res);
    merge_result_t r;
    int unsigned gap;
    in_if.valid       <= 1'b1;
    in_if.command     <= cmd;
    in_if.list_select <= sel;
    in_if.value       <= val;
    do @(posedge clk_i); while (!in_if.ready);
    r = merge_step(cmd, sel, val);
    if (cmd == CMD_POP) min_results_q.push_back(pinned ? pinned_res : r);
    else last_val[sel] = val;
    words_accepted++;
    // Bursts of random length; a gap of zero keeps valid high straight through.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(0, 23);
    end
  endtask

  task automatic send_random(int unsigned count);
    logic [SEL_W-1:0] sel;
    repeat (count) begin
      sel = SEL_W'($urandom_range(0, NUM_LISTS - 1));
      // Pops carry random select and value bits; the block ignores them.
      if ($urandom_range(0, 99) < 45) send_word(CMD_POP, sel, VALUE_W'($urandom), 1'b0, '0);
      else send_word(CMD_APPEND, sel, next_value(sel), 1'b0, '0);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit: a hung handshake ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL k_way_sorted_merge");
      $finish;
    end
  end

  // Receiver: stretches of always-ready, coin-flip, mostly-stalled and mostly-ready,
  // plus one long hold-off so pops back up and the input stalls.
  initial begin
    int unsigned mode;
    int unsigned span;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!hold_done && words_accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 120);
      repeat (span) begin
        case (mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= ($urandom_range(0, 1) != 0);
          2: out_if.ready <= ($urandom_range(0, 4) == 0);
          default: out_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Check every popped word against the oldest expectation.
  always @(posedge clk_i) begin
    merge_result_t got;
    merge_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.min_value     = out_if.min_value;
      got.source_list   = out_if.source_list;
      got.all_empty     = out_if.all_empty;
      got.overflow_seen = out_if.overflow_seen;
      if (min_results_q.size() == 0) begin
        report_mismatch("unexpected word", '0, got);
      end else begin
        want = min_results_q.pop_front();
        if (got.min_value !== want.min_value || got.source_list !== want.source_list ||
            got.all_empty !== want.all_empty || got.overflow_seen !== want.overflow_seen)
          report_mismatch("mismatch", want, got);
      end
    end
  end

  initial begin
    logic [SEL_W-1:0] fill_sel;
    int unsigned      queued;

    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.command     <= CMD_APPEND;
    in_if.list_select <= '0;
    in_if.value       <= '0;
    overflow_flag  = 1'b0;
    words_accepted = 0;
    burst_left     = 0;
    fail_count     = 0;
    cycle_count    = 0;
    hold_done      = 1'b0;
    // Start every run at the same point so copies and small steps make ties.
    foreach (last_val[k]) last_val[k] = -32'sd50;

    // Pinned rows: empty after reset, the value extremes, the tie order and
    // an out-of-order run; the last two pops go through the shadow.
    directed_rows = '{
      '{CMD_POP,    3'd0, 32'sd0,          1'b1, '{32'sd0,          3'd0, 1'b1, 1'b0}},
      '{CMD_APPEND, 3'd7, 32'sh7FFF_FFFF,  1'b0, '0},
      '{CMD_APPEND, 3'd0, 32'sh8000_0000,  1'b0, '0},
      '{CMD_APPEND, 3'd3, 32'shFFFF_FFFF,  1'b0, '0},
      '{CMD_APPEND, 3'd5, 32'sd0,          1'b0, '0},
      '{CMD_POP,    3'd0, 32'sd0,          1'b1, '{32'sh8000_0000,  3'd0, 1'b0, 1'b0}},
      '{CMD_POP,    3'd0, 32'sd0,          1'b1, '{32'shFFFF_FFFF,  3'd3, 1'b0, 1'b0}},
      '{CMD_POP,    3'd0, 32'sd0,          1'b1, '{32'sd0,          3'd5, 1'b0, 1'b0}},
      '{CMD_POP,    3'd0, 32'sd0,          1'b1, '{32'sh7FFF_FFFF,  3'd7, 1'b0, 1'b0}},
      '{CMD_POP,    3'd0, 32'sd0,          1'b1, '{32'sd0,          3'd0, 1'b1, 1'b0}},
      '{CMD_APPEND, 3'd6, 32'sd5,          1'b0, '0},
      '{CMD_APPEND, 3'd2, 32'sd5,          1'b0, '0},
      '{CMD_APPEND, 3'd1, 32'sd5,          1'b0, '0},
      '{CMD_APPEND, 3'd4, 32'sh5555_5555,  1'b0, '0},
      '{CMD_APPEND, 3'd4, 32'shAAAA_AAAA,  1'b0, '0},
      '{CMD_POP,    3'd0, 32'sd0,          1'b1, '{32'sd5,          3'd1, 1'b0, 1'b0}},
      '{CMD_POP,    3'd0, 32'sd0,          1'b1, '{32'sd5,          3'd2, 1'b0, 1'b0}},
      '{CMD_POP,    3'd0, 32'sd0,          1'b1, '{32'sd5,          3'd6, 1'b0, 1'b0}},
      '{CMD_POP,    3'd0, 32'sd0,          1'b1, '{32'sh5555_5555,  3'd4, 1'b0, 1'b0}},
      '{CMD_POP,    3'd0, 32'sd0,          1'b1, '{32'shAAAA_AAAA,  3'd4, 1'b0, 1'b0}},
      '{CMD_POP,    3'd0, 32'sd0,          1'b1, '{32'sd0,          3'd0, 1'b1, 1'b0}},
      '{CMD_APPEND, 3'd2, 32'sd100,        1'b0, '0},
      '{CMD_APPEND, 3'd2, 32'sd200,        1'b0, '0},
      '{CMD_APPEND, 3'd3, 32'sd150,        1'b0, '0},
      '{CMD_POP,    3'd0, 32'sd0,          1'b0, '0},
      '{CMD_POP,    3'd0, 32'sd0,          1'b0, '0}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[k])
      send_word(directed_rows[k].cmd, directed_rows[k].sel, directed_rows[k].val,
                directed_rows[k].pinned, directed_rows[k].res);

    send_random(500);

    // Fill one sequence to the top, push a few more to trip the overflow,
    // then drain everything, past empty, so heads wrap the whole ring.
    fill_sel = SEL_W'($urandom_range(0, NUM_LISTS - 1));
    while (seq_q[fill_sel].size() < LIST_DEPTH)
      send_word(CMD_APPEND, fill_sel, next_value(fill_sel), 1'b0, '0);
    repeat (4) send_word(CMD_APPEND, fill_sel, next_value(fill_sel), 1'b0, '0);
    queued = 0;
    foreach (seq_q[k]) queued += seq_q[k].size();
    repeat (queued + 2) send_word(CMD_POP, '0, '0, 1'b0, '0);

    send_random(300);

    // Drop valid, let every pop come back, then wait TAIL_CYCLES for strays.
    in_if.valid <= 1'b0;
    while (min_results_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("PASS k_way_sorted_merge");
    end else begin
      $display("FAIL k_way_sorted_merge");
    end
    $finish;
  end

endmodule
